// ----- hw/rtl/twtt_pkg.sv -----
// twtt_pkg: shared widths, request and result codes, and structs for the
// timing wheel timeout table. No dependencies.
package twtt_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned RK_W    = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned DVD_W   = 17;
  localparam int unsigned STEP_W  = 5;

  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REFRESH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;

  localparam logic [RK_W-1:0] RK_STATUS    = 2'd0;
  localparam logic [RK_W-1:0] RK_EXPIRED   = 2'd1;
  localparam logic [RK_W-1:0] RK_TICK_DONE = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd60;

  typedef struct packed {
    logic               valid;
    logic               cancelled;
    logic [DELAY_W-1:0] delay;
    logic [POS_W-1:0]   expiry;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [POS_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ----- hw/rtl/timing_wheel_timeout_table.sv -----
// timing_wheel_timeout_table: top level of the timing wheel timeout table.
// Depends on twtt_pkg, twtt_cell and twtt_mod.
//
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_kind, in_timer_slot, in_delay_ticks
// out_      output     out_valid / out_stall  out_result_kind, out_expired_slot,
//                                             out_present, out_last
// cfg_      input      cfg_valid / cfg_ready  cfg_wheel_size
//
// Each item is accepted, runs through the bit-serial remainder unit until
// the remainder is taken, rotates the cell ring past the head entry by
// entry, and ends by posting the closing result.
// in_stall is high from acceptance until the closing result sits in the
// output register; that result may wait there while the next item enters.
// out_stall freezes the ring whenever the output register is full and stalled.
// Reset (synchronous, rst_n low) clears all entries, the wheel position
// and sets the wheel size to 60; no clearing pass is needed.
module timing_wheel_timeout_table #(
  parameter int NUM_TIMERS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [twtt_pkg::KIND_W-1:0]  in_kind,
  input  logic [twtt_pkg::SLOT_W-1:0]  in_timer_slot,
  input  logic [twtt_pkg::DELAY_W-1:0] in_delay_ticks,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [twtt_pkg::RK_W-1:0]    out_result_kind,
  output logic [twtt_pkg::SLOT_W-1:0]  out_expired_slot,
  output logic                         out_present,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [twtt_pkg::SIZE_W-1:0]  cfg_wheel_size
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_K = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_SCAN, S_LAST} state_t;

  state_t                       state_r;
  logic [twtt_pkg::SIZE_W-1:0]  size_r;
  logic [twtt_pkg::SIZE_W-1:0]  size_eff;
  logic [twtt_pkg::POS_W-1:0]   pos_r;
  logic [twtt_pkg::POS_W-1:0]   calc_r;
  logic [twtt_pkg::KIND_W-1:0]  kind_r;
  logic [twtt_pkg::SLOT_W-1:0]  slot_r;
  logic [twtt_pkg::DELAY_W-1:0] delay_r;
  logic [IDX_W-1:0]             k_r;
  logic                         pres_r;

  logic                         out_valid_r;
  logic [twtt_pkg::RK_W-1:0]    out_kind_r;
  logic [twtt_pkg::SLOT_W-1:0]  out_slot_r;
  logic                         out_present_r;
  logic                         out_last_r;

  logic                         in_accept;
  logic                         out_free;
  logic                         out_load;
  logic                         shift_en;
  logic [twtt_pkg::DELAY_W-1:0] rd_delay;
  logic [twtt_pkg::DELAY_W-1:0] operand;

  twtt_pkg::mod_req_t mod_req;
  twtt_pkg::mod_rsp_t mod_rsp;

  twtt_pkg::entry_t chain [NUM_TIMERS];
  twtt_pkg::entry_t head;
  twtt_pkg::entry_t head_nxt;
  logic             head_hit;
  logic             head_emit;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign shift_en  = (state_r == S_SCAN) && out_free;
  // load the output register with an expiry or with the closing item
  assign out_load  = out_free &&
                     (((state_r == S_SCAN) && head_emit) || (state_r == S_LAST));

  // clamp the wheel size into its legal range
  always_comb begin
    if (size_r < twtt_pkg::SIZE_MIN) begin
      size_eff = twtt_pkg::SIZE_MIN;
    end else if (size_r > twtt_pkg::SIZE_MAX) begin
      size_eff = twtt_pkg::SIZE_MAX;
    end else begin
      size_eff = size_r;
    end
  end

  // stored delay of the named entry, needed before the ring turns for a refresh
  always_comb begin
    rd_delay = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (6'(i) == {1'b0, in_timer_slot}) begin
        rd_delay = chain[i].delay;
      end
    end
  end

  // pick what to add to the position: delay, stored delay, one tick or zero
  always_comb begin
    unique case (in_kind)
      twtt_pkg::KIND_ADD:     operand = in_delay_ticks;
      twtt_pkg::KIND_REFRESH: operand = rd_delay;
      twtt_pkg::KIND_TICK:    operand = 16'd1;
      default:                operand = '0;
    endcase
  end

  assign mod_req.start    = in_accept;
  assign mod_req.dividend = twtt_pkg::DVD_W'(pos_r) + twtt_pkg::DVD_W'(operand);
  assign mod_req.divisor  = size_eff;

  twtt_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // the ring: cell i hands its entry to cell i-1; the head feeds the tail
  genvar gi;
  generate
    for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
      if (gi == NUM_TIMERS - 1) begin : g_tail
        twtt_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .din      (head_nxt),
          .dout     (chain[gi])
        );
      end else begin : g_body
        twtt_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .din      (chain[gi+1]),
          .dout     (chain[gi])
        );
      end
    end
  endgenerate

  assign head = chain[0];

  // Entry k sits at the head during scan step k. A tick drops every valid
  // entry that lands on the new position and reports it unless cancelled;
  // a request edits its own entry when it passes.
  always_comb begin
    head_nxt  = head;
    head_hit  = 1'b0;
    head_emit = 1'b0;
    if (kind_r == twtt_pkg::KIND_TICK) begin
      if (head.valid && (head.expiry == pos_r)) begin
        head_nxt.valid     = 1'b0;
        head_nxt.cancelled = 1'b0;
        head_emit          = !head.cancelled;
      end
    end else if (6'(k_r) == {1'b0, slot_r}) begin
      head_hit = 1'b1;
      unique case (kind_r)
        twtt_pkg::KIND_ADD: begin
          head_nxt.valid     = 1'b1;
          head_nxt.cancelled = 1'b0;
          head_nxt.delay     = delay_r;
          head_nxt.expiry    = calc_r;
        end
        twtt_pkg::KIND_REFRESH: begin
          if (head.valid) begin
            head_nxt.expiry = calc_r;
          end
        end
        twtt_pkg::KIND_CANCEL: begin
          if (head.valid) begin
            head_nxt.cancelled = 1'b1;
          end
        end
        default: begin
          head_nxt = head;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      size_r      <= twtt_pkg::SIZE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_wheel_size;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            kind_r  <= in_kind;
            slot_r  <= in_timer_slot;
            delay_r <= in_delay_ticks;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_rsp.done) begin
            calc_r <= mod_rsp.rem;
            if (kind_r == twtt_pkg::KIND_TICK) begin
              pos_r <= mod_rsp.rem;
            end
            k_r     <= '0;
            pres_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (out_free) begin
            if (head_emit) begin
              out_kind_r    <= twtt_pkg::RK_EXPIRED;
              out_slot_r    <= twtt_pkg::SLOT_W'(k_r);
              out_present_r <= 1'b1;
              out_last_r    <= 1'b0;
            end
            if (head_hit) begin
              pres_r <= head_nxt.valid;
            end
            if (k_r == LAST_K) begin
              state_r <= S_LAST;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_LAST: begin
          // post the closing item: tick done or request status
          if (out_free) begin
            out_last_r  <= 1'b1;
            if (kind_r == twtt_pkg::KIND_TICK) begin
              out_kind_r    <= twtt_pkg::RK_TICK_DONE;
              out_slot_r    <= '0;
              out_present_r <= 1'b0;
            end else begin
              out_kind_r    <= twtt_pkg::RK_STATUS;
              out_slot_r    <= slot_r;
              out_present_r <= pres_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_expired_slot = out_slot_r;
  assign out_present      = out_present_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_mod_only_in_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_rsp.busy || mod_rsp.done) |-> (state_r == S_MOD))
    else $error("remainder unit active outside the remainder state");

  a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> ((state_r == S_MOD) && mod_rsp.busy))
    else $error("accepted item did not start the remainder unit");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MOD) && mod_rsp.done && (kind_r == twtt_pkg::KIND_TICK))
      |=> ({1'b0, pos_r} < size_eff))
    else $error("wheel position beyond wheel size after tick");

  a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && out_valid_r) |-> out_last_r)
    else $error("idle with a non-final item still pending");
`endif

endmodule

// ----- hw/rtl/twtt_cell.sv -----
// twtt_cell: one timer entry of the shift ring.
// Depends on twtt_pkg (entry_t).
module twtt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  twtt_pkg::entry_t din,
  output twtt_pkg::entry_t dout
);

  logic                         valid_r;
  logic                         cancelled_r;
  logic [twtt_pkg::DELAY_W-1:0] delay_r;
  logic [twtt_pkg::POS_W-1:0]   expiry_r;

  // flags clear on reset, payload is only read behind valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      cancelled_r <= 1'b0;
    end else if (shift_en) begin
      valid_r     <= din.valid;
      cancelled_r <= din.cancelled;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      delay_r  <= din.delay;
      expiry_r <= din.expiry;
    end
  end

  assign dout.valid     = valid_r;
  assign dout.cancelled = cancelled_r;
  assign dout.delay     = delay_r;
  assign dout.expiry    = expiry_r;

endmodule

// ----- hw/rtl/twtt_mod.sv -----
// twtt_mod: bit-serial restoring remainder, one dividend bit per cycle.
// Depends on twtt_pkg (mod_req_t, mod_rsp_t, widths).
module twtt_mod (
  input  logic               clk,
  input  logic               rst_n,
  input  twtt_pkg::mod_req_t req,
  output twtt_pkg::mod_rsp_t rsp
);

  localparam logic [twtt_pkg::STEP_W-1:0] LAST_STEP =
    twtt_pkg::STEP_W'(twtt_pkg::DVD_W - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [twtt_pkg::STEP_W-1:0] step_r;
  logic [twtt_pkg::DVD_W-1:0]  dvd_r;
  logic [twtt_pkg::SIZE_W-1:0] dvs_r;
  logic [twtt_pkg::SIZE_W-1:0] rem_r;
  logic [twtt_pkg::SIZE_W:0]   shifted;
  logic [twtt_pkg::SIZE_W:0]   diff;
  logic                        ge;

  assign shifted = {rem_r, dvd_r[twtt_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[twtt_pkg::DVD_W-2:0], 1'b0};
        rem_r <= ge ? diff[twtt_pkg::SIZE_W-1:0] : shifted[twtt_pkg::SIZE_W-1:0];
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[twtt_pkg::POS_W-1:0];

endmodule

// ----- bench/tb_timing_wheel_timeout_table.sv -----
// tb_timing_wheel_timeout_table: self-checking bench for the timing wheel timeout table.
// Drives requests and ticks, predicts every status, expiry and tick-finished item.
// Depends on twtt_pkg and the timing_wheel_timeout_table RTL.
module tb_timing_wheel_timeout_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TIMERS     = 32;
  // Wait after draining, long enough for one item to pass through the block.
  localparam int DRAIN_CYCLES   = 64;
  // Limit on cycles without any handshake. The slowest correct gap is a long
  // sender gap plus a long receiver stall plus one pass over the ring.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 33;

  // Codes beyond tick are handled as a check by the block.
  localparam logic [twtt_pkg::KIND_W-1:0] KIND_UNKNOWN_LO = 3'd5;
  localparam logic [twtt_pkg::KIND_W-1:0] KIND_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [twtt_pkg::KIND_W-1:0]  kind;
    logic [twtt_pkg::SLOT_W-1:0]  slot;
    logic [twtt_pkg::DELAY_W-1:0] delay;
  } timer_request_t;

  typedef struct packed {
    logic [twtt_pkg::RK_W-1:0]   result_kind;
    logic [twtt_pkg::SLOT_W-1:0] slot;
    logic                        present;
    logic                        last;
  } timer_result_t;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_stall;
  logic [twtt_pkg::KIND_W-1:0]   in_kind        = '0;
  logic [twtt_pkg::SLOT_W-1:0]   in_timer_slot  = '0;
  logic [twtt_pkg::DELAY_W-1:0]  in_delay_ticks = '0;
  logic                          out_valid;
  logic                          out_stall      = 1'b0;
  logic [twtt_pkg::RK_W-1:0]     out_result_kind;
  logic [twtt_pkg::SLOT_W-1:0]   out_expired_slot;
  logic                          out_present;
  logic                          out_last;
  logic                          cfg_valid      = 1'b0;
  logic                          cfg_ready;
  logic [twtt_pkg::SIZE_W-1:0]   cfg_wheel_size = '0;

  timing_wheel_timeout_table #(
    .NUM_TIMERS(NUM_TIMERS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_timer_slot   (in_timer_slot),
    .in_delay_ticks  (in_delay_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_expired_slot(out_expired_slot),
    .out_present     (out_present),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_wheel_size  (cfg_wheel_size)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the timer table, kept in step with every accepted item.
  logic [twtt_pkg::SIZE_W-1:0]  shadow_wheel_size = twtt_pkg::SIZE_RESET;
  logic [twtt_pkg::POS_W-1:0]   shadow_position   = '0;
  logic                         shadow_armed     [NUM_TIMERS];
  logic                         shadow_silenced  [NUM_TIMERS];
  logic [twtt_pkg::DELAY_W-1:0] shadow_delay     [NUM_TIMERS];
  logic [twtt_pkg::POS_W-1:0]   shadow_expiry    [NUM_TIMERS];

  timer_request_t pending_requests[$];
  timer_result_t  expected_results[$];

  int unsigned    queued_count   = 0;
  int             mismatch_count = 0;
  bit             calm           = 1'b0;
  int unsigned    in_gap_left    = 0;
  int unsigned    stall_left     = 0;
  int unsigned    idle_cycles    = 0;
  timer_request_t req_now;
  timer_result_t  want;

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      shadow_armed[i]    = 1'b0;
      shadow_silenced[i] = 1'b0;
      shadow_delay[i]    = '0;
      shadow_expiry[i]   = '0;
    end
  end

  // Clamp the register into the legal wheel range.
  function automatic int unsigned effective_wheel_size(
    input logic [twtt_pkg::SIZE_W-1:0] v
  );
    if (v < twtt_pkg::SIZE_MIN) return int'(twtt_pkg::SIZE_MIN);
    if (v > twtt_pkg::SIZE_MAX) return int'(twtt_pkg::SIZE_MAX);
    return int'(v);
  endfunction

  // Apply one accepted item to the shadow table and queue what it must produce.
  function automatic void predict_timer_results(input timer_request_t req);
    int unsigned   size;
    int unsigned   sum;
    timer_result_t res;
    size = effective_wheel_size(shadow_wheel_size);
    if (req.kind == twtt_pkg::KIND_TICK) begin
      // Advance the wheel, then sweep the entries in ascending order.
      sum = (int'(shadow_position) + 1) % size;
      shadow_position = sum[twtt_pkg::POS_W-1:0];
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (shadow_armed[i] && shadow_expiry[i] == shadow_position) begin
          shadow_armed[i] = 1'b0;
          if (!shadow_silenced[i]) begin
            res.result_kind = twtt_pkg::RK_EXPIRED;
            res.slot        = i[twtt_pkg::SLOT_W-1:0];
            res.present     = 1'b1;
            res.last        = 1'b0;
            expected_results.insert(expected_results.size(), res);
          end
          shadow_silenced[i] = 1'b0;
        end
      end
      res.result_kind = twtt_pkg::RK_TICK_DONE;
      res.slot        = '0;
      res.present     = 1'b0;
      res.last        = 1'b1;
      expected_results.insert(expected_results.size(), res);
    end else begin
      case (req.kind)
        twtt_pkg::KIND_ADD: begin
          // Replace whatever sat in the slot, cancellation included.
          sum = (int'(shadow_position) + int'(req.delay)) % size;
          shadow_armed[req.slot]    = 1'b1;
          shadow_silenced[req.slot] = 1'b0;
          shadow_delay[req.slot]    = req.delay;
          shadow_expiry[req.slot]   = sum[twtt_pkg::POS_W-1:0];
        end
        twtt_pkg::KIND_REFRESH: begin
          if (shadow_armed[req.slot]) begin
            sum = (int'(shadow_position) + int'(shadow_delay[req.slot])) % size;
            shadow_expiry[req.slot] = sum[twtt_pkg::POS_W-1:0];
          end
        end
        twtt_pkg::KIND_CANCEL: begin
          if (shadow_armed[req.slot]) shadow_silenced[req.slot] = 1'b1;
        end
        default: begin
        end
      endcase
      res.result_kind = twtt_pkg::RK_STATUS;
      res.slot        = req.slot;
      res.present     = shadow_armed[req.slot];
      res.last        = 1'b1;
      expected_results.insert(expected_results.size(), res);
    end
  endfunction

  // Mostly back to back, often short gaps, now and then a long one.
  function automatic int unsigned pick_idle_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Driver: present the next pending item once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_timer_results('{in_kind, in_timer_slot, in_delay_ticks});
      end
      // Hold the payload steady while the block stalls it.
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0) begin
          in_gap_left <= in_gap_left - 1;
          in_valid    <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req_now        = pending_requests.pop_front();
          in_valid       <= 1'b1;
          in_kind        <= req_now.kind;
          in_timer_slot  <= req_now.slot;
          in_delay_ticks <= req_now.delay;
          in_gap_left    <= pick_idle_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d present %0d last %0d",
                 out_result_kind, out_expired_slot, out_present, out_last);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, out_result_kind);
            mismatch_count++;
          end
          if (out_expired_slot !== want.slot) begin
            $error("expired_slot: expected %0d, got %0d", want.slot, out_expired_slot);
            mismatch_count++;
          end
          if (out_present !== want.present) begin
            $error("present: expected %0d, got %0d", want.present, out_present);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      // Stall the result channel in random bursts, independent of out_valid.
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= pick_idle_gap();
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_request(input logic [twtt_pkg::KIND_W-1:0] kind,
                               input int unsigned slot, input int unsigned delay);
    timer_request_t req;
    req.kind  = kind;
    req.slot  = slot[twtt_pkg::SLOT_W-1:0];
    req.delay = delay[twtt_pkg::DELAY_W-1:0];
    pending_requests.insert(pending_requests.size(), req);
    queued_count++;
  endtask

  // Wait for the block to go quiet: everything sent, everything received.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_wheel_size(input logic [twtt_pkg::SIZE_W-1:0] v);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_wheel_size <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid         <= 1'b0;
    shadow_wheel_size = v;
  endtask

  // One loose random item; slots crowd into a few entries so that refresh
  // and cancel often find a live timer.
  task automatic queue_random_request();
    int unsigned                 size;
    int unsigned                 r;
    int unsigned                 slot;
    int unsigned                 delay;
    logic [twtt_pkg::KIND_W-1:0] kind;
    size = effective_wheel_size(shadow_wheel_size);
    r = $urandom_range(0, 99);
    if (r < 28)      kind = twtt_pkg::KIND_ADD;
    else if (r < 40) kind = twtt_pkg::KIND_REFRESH;
    else if (r < 50) kind = twtt_pkg::KIND_CANCEL;
    else if (r < 57) kind = twtt_pkg::KIND_CHECK;
    else if (r < 62) kind = twtt_pkg::KIND_W'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI));
    else             kind = twtt_pkg::KIND_TICK;
    slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
    r = $urandom_range(0, 99);
    if (r < 35)      delay = $urandom_range(0, 2 * size);
    else if (r < 55) delay = size * $urandom_range(0, 4);
    else if (r < 85) delay = $urandom_range(0, 65535);
    else             delay = $urandom_range(0, 1) ? 65535 : 0;
    queue_request(kind, slot, delay);
  endtask

  // Well-formed sequence: arm one timer, maybe touch it, then tick toward
  // its expiry so that the sweep actually fires.
  task automatic queue_arm_and_run();
    int unsigned size;
    int unsigned slot;
    int unsigned delay;
    int unsigned ticks;
    size  = effective_wheel_size(shadow_wheel_size);
    slot  = $urandom_range(0, 7);
    delay = $urandom_range(0, (size < 12) ? size + 2 : 12);
    queue_request(twtt_pkg::KIND_ADD, slot, delay);
    case ($urandom_range(0, 3))
      0: queue_request(twtt_pkg::KIND_CANCEL, slot, $urandom_range(0, 65535));
      1: queue_request(twtt_pkg::KIND_REFRESH, slot, $urandom_range(0, 65535));
      default: begin
      end
    endcase
    ticks = ((delay % size) == 0) ? size : delay % size;
    if (ticks > 16) ticks = 16;
    repeat (ticks) begin
      queue_request(twtt_pkg::KIND_TICK, $urandom_range(0, 31), $urandom_range(0, 65535));
    end
  endtask

  logic [twtt_pkg::SIZE_W-1:0] phase_sizes[10] = '{
    9'd2, 9'd256, 9'd0, 9'd511, 9'd1, 9'd7, 9'd13, 9'd255, 9'd3, 9'd60
  };
  int unsigned phase_target;

  initial begin
    // Directed opening at the reset wheel size of 60.
    queue_request(twtt_pkg::KIND_CHECK,   0,  0);      // absent entry
    queue_request(twtt_pkg::KIND_REFRESH, 5,  65535);  // refresh of an absent entry
    queue_request(twtt_pkg::KIND_CANCEL,  6,  0);      // cancel of an absent entry
    queue_request(twtt_pkg::KIND_ADD,     0,  0);      // zero delay waits a full turn
    queue_request(twtt_pkg::KIND_ADD,     31, 65535);  // largest delay, top slot
    queue_request(twtt_pkg::KIND_ADD,     1,  1);
    queue_request(twtt_pkg::KIND_ADD,     2,  60);     // exact multiple of the wheel
    queue_request(twtt_pkg::KIND_ADD,     3,  2);
    queue_request(twtt_pkg::KIND_CANCEL,  3,  0);
    queue_request(twtt_pkg::KIND_REFRESH, 3,  0);      // re-armed, still silent
    queue_request(twtt_pkg::KIND_ADD,     4,  1);
    queue_request(twtt_pkg::KIND_ADD,     4,  3);      // replace a live entry
    queue_request(twtt_pkg::KIND_CANCEL,  1,  0);
    queue_request(twtt_pkg::KIND_ADD,     1,  1);      // re-add clears the cancel
    queue_request(KIND_UNKNOWN_LO,                             31, 65535);
    queue_request(twtt_pkg::KIND_W'(KIND_UNKNOWN_LO + 3'd1), 2,  0);
    queue_request(KIND_UNKNOWN_HI,                             31, 0);
    queue_request(twtt_pkg::KIND_TICK,    31, 65535);  // slot 1 fires
    queue_request(twtt_pkg::KIND_TICK,    0,  0);      // slot 3 swept silently
    queue_request(twtt_pkg::KIND_TICK,    0,  0);      // slot 4 fires
    queue_request(twtt_pkg::KIND_CHECK,   3,  0);
    queue_request(twtt_pkg::KIND_TICK,    0,  0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Random phases, each under a new wheel size; live timers carry over so
    // that resizing with armed entries gets exercised too.
    foreach (phase_sizes[p]) begin
      write_wheel_size(phase_sizes[p]);
      calm = (p == 3 || p == 7);
      phase_target = queued_count + PHASE_ITEMS;
      while (queued_count < phase_target) begin
        if ($urandom_range(0, 3) == 0) queue_arm_and_run();
        else queue_random_request();
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/twtt_pkg.sv
hw/rtl/twtt_cell.sv
hw/rtl/twtt_mod.sv
hw/rtl/timing_wheel_timeout_table.sv
bench/tb_timing_wheel_timeout_table.sv
